// File: sv/xsid_pkg.sv
// ----------------------------------------------------------------------------
// xsid_pkg
// shared types and constants for the x86-64 subset instruction decoder
// ----------------------------------------------------------------------------
package xsid_pkg;

  localparam int unsigned OffsetBitsDefault = 32;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_AFTER_REX = 3'd1,
    PH_ESCAPE    = 3'd2,
    PH_MODRM     = 3'd3,
    PH_SIB       = 3'd4,
    PH_DISP      = 3'd5,
    PH_IMM       = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_BAD_SEL   = 2'd2,
    ST_UNKNOWN0F = 2'd3
  } status_e;

  localparam logic [4:0] MnImul    = 5'd13;
  localparam logic [4:0] MnJcc     = 5'd14;
  localparam logic [4:0] MnSetcc   = 5'd15;
  localparam logic [4:0] MnBadSel  = 5'd26;
  localparam logic [4:0] MnUnknown = 5'd27;

  // decoded record, packed with status in the low bits when flattened
  typedef struct packed {
    logic [3:0]  byte_length;
    logic [31:0] start_offset;
    logic [63:0] immediate_value;
    logic [31:0] displacement;
    logic [7:0]  sib_byte;
    logic [7:0]  modrm_byte;
    logic        rex_seen;
    logic [3:0]  rex_bits;
    logic [3:0]  condition_code;
    logic [4:0]  mnemonic;
    logic [1:0]  status;
  } rec_t;

  function automatic logic [4:0] classify(input logic [7:0] op, input logic esc,
                                          input logic [2:0] sel);
    logic [4:0] r;
    r = MnUnknown;
    if (esc) begin
      if (op == 8'hAF) r = MnImul;
      else if (op[7:4] == 4'h8) r = MnJcc;
      else if (op[7:4] == 4'h9) r = MnSetcc;
      else if (op == 8'hB6) r = 5'd16;
    end else if (op[7:3] == 5'b01010) r = 5'd0;
    else if (op[7:3] == 5'b01011) r = 5'd1;
    else if (op[7:3] == 5'b10111) r = 5'd5;
    else begin
      case (op)
        8'h8B: r = 5'd2;
        8'h89: r = 5'd3;
        8'h8D: r = 5'd4;
        8'h03: r = 5'd6;
        8'h2B: r = 5'd7;
        8'h81: r = (sel == 3'd5) ? 5'd8 : MnBadSel;
        8'h3B: r = 5'd9;
        8'h85: r = 5'd10;
        8'hE9: r = 5'd11;
        8'h99: r = 5'd12;
        8'hF7: r = (sel == 3'd7) ? 5'd17 : (sel == 3'd3) ? 5'd18 :
                   (sel == 3'd2) ? 5'd19 : MnBadSel;
        8'hD3: r = (sel == 3'd4) ? 5'd20 : (sel == 3'd7) ? 5'd21 : MnBadSel;
        8'h23: r = 5'd22;
        8'h0B: r = 5'd23;
        8'h33: r = 5'd24;
        8'hC3: r = 5'd25;
        default: r = MnUnknown;
      endcase
    end
    return r;
  endfunction

  function automatic logic wants_modrm(input logic [7:0] op, input logic esc);
    if (esc) return op == 8'hAF || op[7:4] == 4'h9 || op == 8'hB6;
    return op inside {8'h8B, 8'h89, 8'h8D, 8'h81, 8'h03, 8'h2B, 8'h3B, 8'h85,
                      8'hF7, 8'hD3, 8'h23, 8'h0B, 8'h33};
  endfunction

  function automatic logic full_modrm(input logic [7:0] op, input logic esc);
    return !esc && (op inside {8'h8B, 8'h89, 8'h8D, 8'h81});
  endfunction

  function automatic logic [3:0] imm_len(input logic [7:0] op, input logic esc,
                                         input logic rex_w);
    if (esc) return (op[7:4] == 4'h8) ? 4'd4 : 4'd0;
    if (op == 8'h81 || op == 8'hE9) return 4'd4;
    if (op[7:3] == 5'b10111) return rex_w ? 4'd8 : 4'd4;
    return 4'd0;
  endfunction

endpackage

// File: sv/xsid_core.sv
// ----------------------------------------------------------------------------
// xsid_core
// byte-level decode state and record forming, one byte per cycle while step_i is high
// ----------------------------------------------------------------------------
module xsid_core #(
  parameter int unsigned OffsetBits = xsid_pkg::OffsetBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output logic           rec_valid_o,
  output xsid_pkg::rec_t rec_o
);
  import xsid_pkg::*;

  phase_e                phase_q, phase_d;
  logic [4:0]            rex_q, rex_d;
  logic [7:0]            op_q, op_d;
  logic                  esc_q, esc_d;
  logic [7:0]            modrm_q, modrm_d;
  logic [7:0]            sib_q, sib_d;
  logic [31:0]           disp_q, disp_d;
  logic [63:0]           imm_q, imm_d;
  logic [3:0]            rem_q, rem_d;
  logic [OffsetBits-1:0] cnt_q, cnt_d;
  logic [OffsetBits-1:0] start_q, start_d;

  logic       emit;
  logic [1:0] st;
  logic       done;
  logic [4:0] mn;
  logic [3:0] il;
  logic [1:0] mode;
  logic [OffsetBits-1:0] span;
  logic [63:0] immv;
  logic [31:0] dispv;
  logic [3:0] dec;

  // next state of all fields; done marks the end of a complete instruction, good or bad select
  always_comb begin
    phase_d = phase_q; rex_d = rex_q; op_d = op_q; esc_d = esc_q;
    modrm_d = modrm_q; sib_d = sib_q; disp_d = disp_q; imm_d = imm_q;
    rem_d = rem_q; start_d = start_q;
    emit = 1'b0; st = ST_OK; done = 1'b0;
    mode = modrm_q[7:6];
    dec = (rem_q != 4'd0) ? rem_q - 4'd1 : 4'd0;
    case (phase_q)
      PH_IDLE, PH_AFTER_REX: begin
        if (phase_q == PH_IDLE) begin
          start_d = cnt_q; rex_d = '0; op_d = '0; esc_d = 1'b0;
          modrm_d = '0; sib_d = '0; disp_d = '0; imm_d = '0; rem_d = '0;
        end
        if (phase_q == PH_IDLE && byte_i[7:4] == 4'h4) begin
          rex_d = {1'b1, byte_i[3:0]};
          phase_d = PH_AFTER_REX;
        end else begin
          op_d = byte_i;
          if (byte_i == 8'h0F) phase_d = PH_ESCAPE;
          else begin
            esc_d = 1'b0;
            if (classify(byte_i, 1'b0, modrm_d[5:3]) == MnUnknown) phase_d = PH_IDLE;
            else if (wants_modrm(byte_i, 1'b0)) phase_d = PH_MODRM;
            else begin
              il = imm_len(byte_i, 1'b0, rex_d[3]);
              if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
              else begin done = 1'b1; phase_d = PH_IDLE; end
            end
          end
        end
      end
      PH_ESCAPE: begin
        op_d = byte_i; esc_d = 1'b1;
        if (classify(byte_i, 1'b1, modrm_q[5:3]) == MnUnknown) begin
          phase_d = PH_IDLE; emit = 1'b1; st = ST_UNKNOWN0F;
        end else if (wants_modrm(byte_i, 1'b1)) phase_d = PH_MODRM;
        else begin
          il = imm_len(byte_i, 1'b1, rex_q[3]);
          if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
          else begin done = 1'b1; phase_d = PH_IDLE; end
        end
      end
      PH_MODRM: begin
        modrm_d = byte_i;
        mode = byte_i[7:6];
        if (!full_modrm(op_q, esc_q) || mode == 2'd3) begin
          il = imm_len(op_q, esc_q, rex_q[3]);
          if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
          else begin done = 1'b1; phase_d = PH_IDLE; end
        end else if (byte_i[2:0] == 3'd4) phase_d = PH_SIB;
        else if (mode == 2'd1) begin rem_d = 4'd1; phase_d = PH_DISP; end
        else if (mode == 2'd2 || byte_i[2:0] == 3'd5) begin
          rem_d = 4'd4; phase_d = PH_DISP;
        end else begin
          il = imm_len(op_q, esc_q, rex_q[3]);
          if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
          else begin done = 1'b1; phase_d = PH_IDLE; end
        end
      end
      PH_SIB: begin
        sib_d = byte_i;
        if (mode == 2'd1) begin rem_d = 4'd1; phase_d = PH_DISP; end
        else if (mode == 2'd2 || byte_i[2:0] == 3'd5) begin
          rem_d = 4'd4; phase_d = PH_DISP;
        end else begin
          il = imm_len(op_q, esc_q, rex_q[3]);
          if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
          else begin done = 1'b1; phase_d = PH_IDLE; end
        end
      end
      PH_DISP: begin
        disp_d = {byte_i, disp_q[31:8]};
        rem_d = dec;
        if (dec == 4'd0) begin
          il = imm_len(op_q, esc_q, rex_q[3]);
          if (il != 4'd0) begin rem_d = il; phase_d = PH_IMM; end
          else begin done = 1'b1; phase_d = PH_IDLE; end
        end
      end
      PH_IMM: begin
        imm_d = {byte_i, imm_q[63:8]};
        rem_d = dec;
        if (dec == 4'd0) begin done = 1'b1; phase_d = PH_IDLE; end
      end
      default: phase_d = PH_IDLE;
    endcase
    il = imm_len(op_d, esc_d, rex_d[3]);
    mn = classify(op_d, esc_d, modrm_d[5:3]);
    if (done) begin
      emit = 1'b1;
      st = (mn == MnBadSel || mn == MnUnknown) ? ST_BAD_SEL : ST_OK;
    end
    if (last_i && !emit && phase_d != PH_IDLE) begin
      emit = 1'b1; st = ST_TRUNC; phase_d = PH_IDLE;
    end
    cnt_d = last_i ? '0 : cnt_q + 1'b1;
  end

  // value views of the captured fields
  always_comb begin
    if (modrm_d[7:6] == 2'd1) dispv = {{24{disp_d[31]}}, disp_d[31:24]};
    else dispv = disp_d;
    if (il == 4'd8) immv = imm_d;
    else if (il == 4'd0) immv = '0;
    else if (!esc_d && op_d[7:3] == 5'b10111) immv = {32'd0, imm_d[63:32]};
    else immv = {{32{imm_d[63]}}, imm_d[63:32]};
    span = cnt_q - start_d;
  end

  // record register loads at this edge
  assign rec_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; rex_q <= '0; op_q <= '0; esc_q <= 1'b0;
      modrm_q <= '0; sib_q <= '0; disp_q <= '0; imm_q <= '0; rem_q <= '0;
      cnt_q <= '0; start_q <= '0;
    end else begin
      if (step_i) begin
        phase_q <= phase_d; rex_q <= rex_d; op_q <= op_d; esc_q <= esc_d;
        modrm_q <= modrm_d; sib_q <= sib_d; disp_q <= disp_d; imm_q <= imm_d;
        rem_q <= rem_d; cnt_q <= cnt_d; start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && emit) begin
      rec_o.status          <= st;
      rec_o.mnemonic        <= (st == ST_OK) ? mn : 5'd0;
      rec_o.condition_code  <= (st == ST_OK && (mn == MnJcc || mn == MnSetcc)) ?
                               op_d[3:0] : 4'd0;
      rec_o.rex_bits        <= rex_d[3:0];
      rec_o.rex_seen        <= rex_d[4];
      rec_o.modrm_byte      <= modrm_d;
      rec_o.sib_byte        <= sib_d;
      rec_o.displacement    <= (st == ST_OK) ? dispv : 32'd0;
      rec_o.immediate_value <= (st == ST_OK) ? immv : 64'd0;
      rec_o.start_offset    <= 32'(start_d);
      rec_o.byte_length     <= span[3:0] + 4'd1;
    end
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd8) else $error("remaining count out of range");
  a_idle_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DISP) |-> (rem_q != 4'd0)) else $error("disp with no bytes left");
  a_trunc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (phase_q == PH_IDLE && cnt_q == '0))
    else $error("buffer end did not resync");
endmodule

// File: sv/x86_64_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// x86_64_subset_instruction_decoder
// streaming decoder for a subset of x86-64 machine code
// ----------------------------------------------------------------------------
// usage:
//  - slave side takes one code byte per beat: tdata = code_byte, tlast marks
//    the final byte of the code buffer
//  - master side gives one decoded record per finished instruction, or an
//    error record on truncation, unknown select or unknown 0f opcode
//  - unknown lead bytes are eaten with no record
//  - throughput: one byte per cycle while not stalled; a record is valid from
//    the clock edge that takes its final byte, held in a single output
//    register
//  - stall: while a record waits untaken, s_axis_tready stays low; it is
//    high whenever the output register is empty or being drained this cycle
//  - reset clears phase, counters and output valid; the decoder waits for a
//    prefix or opcode byte at offset zero
// ----------------------------------------------------------------------------
module x86_64_subset_instruction_decoder #(
  parameter int unsigned OffsetBits = xsid_pkg::OffsetBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // code_byte
  input  logic         s_axis_tlast,   // end_of_buffer
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata    // status, mnemonic, condition_code,
                                       // rex_bits, rex_seen, modrm_byte,
                                       // sib_byte, displacement,
                                       // immediate_value, start_offset,
                                       // byte_length, zero fill
);
  import xsid_pkg::*;

  logic rec_valid;
  rec_t rec;
  logic out_valid_q;
  rec_t out_q;
  logic step;

  // record register can take a new record whenever it is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  xsid_core #(.OffsetBits(OffsetBits)) u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(s_axis_tdata),
    .last_i(s_axis_tlast), .rec_valid_o(rec_valid), .rec_o(rec)
  );

  // core output register already holds the record; this tracks its taking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (rec_valid) out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_comb out_q = rec;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q};

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !rec_valid) else $error("record overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("record changed while stalled");
  a_keep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("record dropped while stalled");
endmodule

// File: tb/xsid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xsid_checker
// watches both streams of the decoder, predicts each record and compares it
// ----------------------------------------------------------------------------
module xsid_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [167:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);
  import xsid_pkg::*;

  localparam logic [4:0] MN_BAD = 5'd26;
  localparam logic [4:0] MN_UNK = 5'd27;

  phase_e      phase;
  logic [4:0]  rex_q;
  logic [7:0]  op_q;
  logic        esc_q;
  logic [7:0]  modrm_q;
  logic [7:0]  sib_q;
  logic [31:0] disp_q;
  logic [63:0] imm_q;
  logic [3:0]  left_q;
  logic [31:0] count_q;
  logic [31:0] start_q;

  rec_t record_q[$];

  assign pending_o = record_q.size();

  // mnemonic lookup for the supported subset
  function automatic logic [4:0] mnem_of();
    logic [2:0] sel;
    sel = modrm_q[5:3];
    if (esc_q) begin
      if (op_q == 8'hAF) return 5'd13;
      if (op_q[7:4] == 4'h8) return 5'd14;
      if (op_q[7:4] == 4'h9) return 5'd15;
      if (op_q == 8'hB6) return 5'd16;
      return MN_UNK;
    end
    if (op_q[7:3] == 5'b01010) return 5'd0;
    if (op_q[7:3] == 5'b01011) return 5'd1;
    if (op_q[7:3] == 5'b10111) return 5'd5;
    case (op_q)
      8'h8B: return 5'd2;
      8'h89: return 5'd3;
      8'h8D: return 5'd4;
      8'h03: return 5'd6;
      8'h2B: return 5'd7;
      8'h81: return sel == 3'd5 ? 5'd8 : MN_BAD;
      8'h3B: return 5'd9;
      8'h85: return 5'd10;
      8'hE9: return 5'd11;
      8'h99: return 5'd12;
      8'hF7: return sel == 3'd7 ? 5'd17 : sel == 3'd3 ? 5'd18 :
                    sel == 3'd2 ? 5'd19 : MN_BAD;
      8'hD3: return sel == 3'd4 ? 5'd20 : sel == 3'd7 ? 5'd21 : MN_BAD;
      8'h23: return 5'd22;
      8'h0B: return 5'd23;
      8'h33: return 5'd24;
      8'hC3: return 5'd25;
      default: return MN_UNK;
    endcase
  endfunction

  function automatic bit has_modrm();
    if (esc_q) return op_q == 8'hAF || op_q[7:4] == 4'h9 || op_q == 8'hB6;
    case (op_q)
      8'h8B, 8'h89, 8'h8D, 8'h81, 8'h03, 8'h2B, 8'h3B, 8'h85,
      8'hF7, 8'hD3, 8'h23, 8'h0B, 8'h33: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit addr_mode();
    return !esc_q && (op_q == 8'h8B || op_q == 8'h89 || op_q == 8'h8D ||
                      op_q == 8'h81);
  endfunction

  function automatic logic [3:0] imm_bytes();
    if (esc_q) return op_q[7:4] == 4'h8 ? 4'd4 : 4'd0;
    if (op_q == 8'h81 || op_q == 8'hE9) return 4'd4;
    if (op_q[7:3] == 5'b10111) return rex_q[3] ? 4'd8 : 4'd4;
    return 4'd0;
  endfunction

  function automatic rec_t make_record(status_e st, logic [4:0] mn);
    rec_t r;
    logic [3:0] n;
    r = '0;
    n = imm_bytes();
    r.status = st;
    r.rex_bits = rex_q[3:0];
    r.rex_seen = rex_q[4];
    r.modrm_byte = modrm_q;
    r.sib_byte = sib_q;
    r.start_offset = start_q;
    r.byte_length = 4'(count_q - start_q + 1);
    if (st == ST_OK) begin
      r.mnemonic = mn;
      if (mn == 5'd14 || mn == 5'd15) r.condition_code = op_q[3:0];
      r.displacement = (modrm_q[7:6] == 2'd1) ? {{24{disp_q[31]}}, disp_q[31:24]}
                                              : disp_q;
      if (n == 4'd8) r.immediate_value = imm_q;
      else if (n == 4'd4) begin
        if (!esc_q && op_q[7:3] == 5'b10111) r.immediate_value = {32'd0, imm_q[63:32]};
        else r.immediate_value = {{32{imm_q[63]}}, imm_q[63:32]};
      end
    end
    return r;
  endfunction

  // close the instruction: ok record or bad select
  task automatic retire(output bit got);
    logic [4:0] mn;
    mn = mnem_of();
    phase = PH_IDLE;
    if (mn == MN_BAD || mn == MN_UNK) record_q.push_back(make_record(ST_BAD_SEL, 5'd0));
    else record_q.push_back(make_record(ST_OK, mn));
    got = 1'b1;
  endtask

  task automatic addressing_done(output bit got);
    logic [3:0] n;
    n = imm_bytes();
    got = 1'b0;
    if (n != 0) begin
      left_q = n;
      phase = PH_IMM;
    end else retire(got);
  endtask

  task automatic opcode_done(output bit got);
    got = 1'b0;
    if (has_modrm()) phase = PH_MODRM;
    else addressing_done(got);
  endtask

  task automatic take_op(logic [7:0] b, output bit got);
    got = 1'b0;
    op_q = b;
    if (b == 8'h0F) phase = PH_ESCAPE;
    else begin
      esc_q = 1'b0;
      if (mnem_of() == MN_UNK) phase = PH_IDLE;
      else opcode_done(got);
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic last);
    bit got;
    logic [1:0] md;
    got = 1'b0;
    md = modrm_q[7:6];
    case (phase)
      PH_IDLE: begin
        start_q = count_q;
        rex_q = '0; op_q = '0; esc_q = 1'b0; modrm_q = '0; sib_q = '0;
        disp_q = '0; imm_q = '0; left_q = '0;
        if (b[7:4] == 4'h4) begin
          rex_q = {1'b1, b[3:0]};
          phase = PH_AFTER_REX;
        end else take_op(b, got);
      end
      PH_AFTER_REX: take_op(b, got);
      PH_ESCAPE: begin
        op_q = b;
        esc_q = 1'b1;
        if (mnem_of() == MN_UNK) begin
          phase = PH_IDLE;
          record_q.push_back(make_record(ST_UNKNOWN0F, 5'd0));
          got = 1'b1;
        end else opcode_done(got);
      end
      PH_MODRM: begin
        modrm_q = b;
        md = b[7:6];
        if (!addr_mode() || md == 2'd3) addressing_done(got);
        else if (b[2:0] == 3'd4) phase = PH_SIB;
        else if (md == 2'd1) begin left_q = 4'd1; phase = PH_DISP; end
        else if (md == 2'd2 || b[2:0] == 3'd5) begin left_q = 4'd4; phase = PH_DISP; end
        else addressing_done(got);
      end
      PH_SIB: begin
        sib_q = b;
        if (md == 2'd1) begin left_q = 4'd1; phase = PH_DISP; end
        else if (md == 2'd2 || b[2:0] == 3'd5) begin left_q = 4'd4; phase = PH_DISP; end
        else addressing_done(got);
      end
      PH_DISP: begin
        disp_q = {b, disp_q[31:8]};
        if (left_q != 0) left_q--;
        if (left_q == 0) addressing_done(got);
      end
      PH_IMM: begin
        imm_q = {b, imm_q[63:8]};
        if (left_q != 0) left_q--;
        if (left_q == 0) retire(got);
      end
      default: phase = PH_IDLE;
    endcase
    // buffer ended in the middle of an instruction
    if (last && !got && phase != PH_IDLE) begin
      record_q.push_back(make_record(ST_TRUNC, 5'd0));
      phase = PH_IDLE;
    end
    count_q = last ? '0 : count_q + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t want;
    rec_t seen;
    if (!rst_ni) begin
      phase = PH_IDLE;
      rex_q = '0; op_q = '0; esc_q = 1'b0; modrm_q = '0; sib_q = '0;
      disp_q = '0; imm_q = '0; left_q = '0; count_q = '0; start_q = '0;
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = rec_t'(m_axis_tdata[$bits(rec_t)-1:0]);
        if (record_q.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %h", $time, seen);
          fail_count_o++;
        end else begin
          want = record_q.pop_front();
          if (seen.status != want.status ||
              seen.mnemonic != want.mnemonic ||
              seen.condition_code != want.condition_code ||
              seen.rex_bits != want.rex_bits ||
              seen.rex_seen != want.rex_seen ||
              seen.modrm_byte != want.modrm_byte ||
              seen.sib_byte != want.sib_byte ||
              seen.displacement != want.displacement ||
              seen.immediate_value != want.immediate_value ||
              seen.start_offset != want.start_offset ||
              seen.byte_length != want.byte_length) begin
            $display("%0t: record mismatch, expected %h, actual %h", $time, want, seen);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// byte stream stimulus for the x86-64 subset decoder with random idling
// ----------------------------------------------------------------------------
// directed instructions cover every opcode and error path, then random
// well-formed instructions mixed with noise bytes and early buffer ends;
// a separate checker predicts and compares every record
// ----------------------------------------------------------------------------
module tb;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;  // code_byte
  logic         s_axis_tlast = 1'b0; // end_of_buffer
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;       // record fields, status in lowest bits

  int fail_count;
  int pending;
  int cycle_count = 0;
  int bytes_sent = 0;
  bit hold_sink = 1'b0;  // long receiver stall request

  localparam int CYCLE_LIMIT = 200000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  x86_64_subset_instruction_decoder dut (.*);

  xsid_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when asked
  initial begin
    int wait_n;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_n == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  bit no_gaps = 1'b0;

  // one beat, with a random gap beforehand
  task automatic send_byte(logic [7:0] b, logic last = 1'b0);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10));
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$], input bit last_at_end = 1'b0);
    foreach (seq[i]) send_byte(seq[i], last_at_end && i == seq.size() - 1);
  endtask

  // build a random well-formed instruction
  function automatic void random_instr(ref logic [7:0] seq[$]);
    logic [7:0] op;
    logic [7:0] m;
    logic [7:0] s;
    bit esc;
    bit w;
    int n;
    seq.delete();
    esc = 1'b0;
    w = 1'b0;
    if ($urandom_range(0, 1)) begin
      op = 8'h40 | 8'($urandom_range(0, 15));
      w = op[3];
      seq.push_back(op);
    end
    case ($urandom_range(0, 12))
      0: op = 8'h50 | 8'($urandom_range(0, 15));
      1: op = 8'hB8 | 8'($urandom_range(0, 7));
      2, 3: op = 8'($urandom_range(0, 1) ? 8'h8B : 8'h89);
      4: op = 8'h8D;
      5: op = 8'h81;
      6: begin
        case ($urandom_range(0, 3))
          0: op = 8'h03; 1: op = 8'h2B; 2: op = 8'h3B; default: op = 8'h85;
        endcase
      end
      7: begin
        case ($urandom_range(0, 3))
          0: op = 8'h23; 1: op = 8'h0B; 2: op = 8'h33; default: op = 8'hF7;
        endcase
      end
      8: op = 8'hD3;
      9: begin
        case ($urandom_range(0, 2))
          0: op = 8'hE9; 1: op = 8'h99; default: op = 8'hC3;
        endcase
      end
      default: begin
        esc = 1'b1;
        seq.push_back(8'h0F);
        case ($urandom_range(0, 4))
          0: op = 8'hAF;
          1: op = 8'h80 | 8'($urandom_range(0, 15));
          2: op = 8'h90 | 8'($urandom_range(0, 15));
          3: op = 8'hB6;
          default: op = 8'($urandom_range(0, 255));
        endcase
      end
    endcase
    seq.push_back(op);
    n = 0;
    if ((esc && (op == 8'hAF || op[7:4] == 4'h9 || op == 8'hB6)) ||
        (!esc && op inside {8'h8B, 8'h89, 8'h8D, 8'h81, 8'h03, 8'h2B, 8'h3B, 8'h85,
                            8'hF7, 8'hD3, 8'h23, 8'h0B, 8'h33})) begin
      m = 8'($urandom_range(0, 255));
      seq.push_back(m);
      if (!esc && op inside {8'h8B, 8'h89, 8'h8D, 8'h81} && m[7:6] != 2'd3) begin
        s = 8'h00;
        if (m[2:0] == 3'd4) begin
          s = 8'($urandom_range(0, 255));
          seq.push_back(s);
        end
        if (m[7:6] == 2'd1) n = 1;
        else if (m[7:6] == 2'd2) n = 4;
        else if (m[2:0] == 3'd5 && m[2:0] != 3'd4) n = 4;
        else if (m[2:0] == 3'd4 && s[2:0] == 3'd5) n = 4;
        repeat (n) seq.push_back(8'($urandom_range(0, 255)));
      end
    end
    n = 0;
    if (esc) n = (op[7:4] == 4'h8) ? 4 : 0;
    else if (op == 8'h81 || op == 8'hE9) n = 4;
    else if (op[7:3] == 5'b10111) n = w ? 8 : 4;
    repeat (n) seq.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] seq[$];
    int cut;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: ops, addressing forms, errors, extremes
    send_seq('{8'h48, 8'h8B, 8'h44, 8'h24, 8'hF8});          // mov, sib, disp8
    send_seq('{8'h89, 8'h84, 8'h05, 8'h78, 8'h56, 8'h34, 8'h12}); // sib disp32
    send_seq('{8'h8D, 8'h04, 8'h25, 8'hFF, 8'hFF, 8'hFF, 8'hFF}); // sib base 5
    send_seq('{8'h8B, 8'h05, 8'h00, 8'h00, 8'h00, 8'h80});   // rip disp32
    send_seq('{8'h41, 8'h57, 8'h5F, 8'h99, 8'hC3});          // push/pop/cqo/ret
    send_seq('{8'h48, 8'hB8, 8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'hFF});
    send_seq('{8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});          // imm32 zero extended
    send_seq('{8'h81, 8'hEC, 8'h00, 8'h00, 8'h00, 8'h80});   // sub imm, negative
    send_seq('{8'h81, 8'hC4, 8'h01, 8'h00, 8'h00, 8'h00});   // bad select
    send_seq('{8'hF7, 8'hF9, 8'hF7, 8'hD8, 8'hF7, 8'hD0, 8'hF7, 8'hC0});
    send_seq('{8'hD3, 8'hE0, 8'hD3, 8'hF8, 8'hD3, 8'hC8});
    send_seq('{8'h0F, 8'h8F, 8'h10, 8'h00, 8'h00, 8'hFF, 8'h0F, 8'h94, 8'hC0});
    send_seq('{8'h0F, 8'hAF, 8'hC1, 8'h0F, 8'hB6, 8'hC0, 8'h0F, 8'h05}); // unknown 0f
    send_seq('{8'h4F, 8'h40, 8'h00, 8'hFF, 8'hE9, 8'hFB, 8'hFF, 8'hFF, 8'hFF});
    send_seq('{8'h03, 8'hC0, 8'h2B, 8'h3F, 8'h3B, 8'h85, 8'h85, 8'hC9});
    send_seq('{8'h23, 8'h00, 8'h0B, 8'h00, 8'h33, 8'hFF});
    send_seq('{8'h48, 8'h81, 8'h6C}, 1'b1);                   // truncated
    send_seq('{8'h90}, 1'b1);                                 // noise at end
    drain_all();

    // long receiver hold while the stream keeps coming
    hold_sink = 1'b1;
    no_gaps = 1'b1;
    repeat (10) begin
      random_instr(seq);
      send_seq(seq);
    end
    no_gaps = 1'b0;
    drain_all();

    // random part
    while (bytes_sent < 600) begin
      case ($urandom_range(0, 9))
        0: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        1: begin
          random_instr(seq);
          cut = $urandom_range(0, seq.size() - 1);
          for (int i = 0; i <= cut; i++) send_byte(seq[i], i == cut);
        end
        default: begin
          random_instr(seq);
          send_seq(seq, $urandom_range(0, 19) == 0);
        end
      endcase
      if ($urandom_range(0, 60) == 0) drain_all();
    end
    drain_all();
    repeat (20) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/xsid_pkg.sv
sv/xsid_core.sv
sv/x86_64_subset_instruction_decoder.sv
tb/xsid_checker.sv
tb/tb.sv
